// ===== rtl/afd_pkg.sv =====
// Shared types and constants for the actuator frame decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package afd_pkg;

    localparam int FRAME_LEN  = 8;
    localparam int IDX_W      = $clog2(FRAME_LEN);
    localparam int BYTE_W     = 8;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 16;
    localparam int M_USER_W   = 5;

    localparam logic [BYTE_W-1:0] HDR_CHAR   = 8'h3C;   // '<'
    localparam logic [BYTE_W-1:0] MOTOR_CHAR = 8'h4D;   // 'M'
    localparam logic [BYTE_W-1:0] SERVO_CHAR = 8'h53;   // 'S'
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'd48;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [FRAME_LEN-1:0][BYTE_W-1:0] t_frame;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_MOTOR = 2'd1,
        KIND_SERVO = 2'd2
    } t_kind;

    // Completed frame handed from the collector to the decoder.
    typedef struct packed {
        logic   vld;
        t_frame bytes;
    } t_frm_xfer;

    typedef struct packed {
        logic              found;
        t_kind             first_kind;
        logic [BYTE_W-1:0] first_value;
        t_kind             second_kind;
        logic [BYTE_W-1:0] second_value;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/afd_collect.sv =====
// Byte collector: gathers received bytes into a frame and holds the completed
// frame until the decoder takes it. Depends on afd_pkg.
`default_nettype none

module afd_collect import afd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_valid,
    input  wire logic [BYTE_W-1:0] i_s_data,
    output logic                   o_s_ready,
    input  wire logic              i_take,
    output t_frm_xfer              o_frm
);

    localparam t_idx LAST = t_idx'(FRAME_LEN - 1);

    t_idx              r_count;
    logic              r_frm_vld;
    logic [BYTE_W-1:0] r_bytes [FRAME_LEN-1];
    t_frame            r_frame;
    t_frame            n_frame;
    logic              accept;
    logic              last_byte;

    assign o_s_ready = !r_frm_vld || i_take;
    assign accept    = i_s_valid && o_s_ready;
    assign last_byte = (r_count == LAST);

    // The final byte goes straight into the snapshot, never into the buffer.
    always_comb begin
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            n_frame[i] = r_bytes[i];
        end
        n_frame[FRAME_LEN-1] = i_s_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_frm_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= r_count + t_idx'(1);
            end
            if (accept && last_byte) begin
                r_frm_vld <= 1'b1;
            end else if (i_take) begin
                r_frm_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !last_byte) begin
            r_bytes[r_count] <= i_s_data;
        end
        if (accept && last_byte) begin
            r_frame <= n_frame;
        end
    end

    assign o_frm.vld   = r_frm_vld;
    assign o_frm.bytes = r_frame;

endmodule

`default_nettype wire

// ===== rtl/afd_decode.sv =====
// Frame decoder: header search, command decode and the result register.
// Depends on afd_pkg.
`default_nettype none

module afd_decode import afd_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_frm_xfer i_frm,
    output logic           o_take,
    output logic           o_m_valid,
    input  wire logic      i_m_ready,
    output t_result        o_res
);

    function automatic t_kind kind_of(input logic [BYTE_W-1:0] sel);
        t_kind k;
        k = KIND_NONE;
        if (sel == MOTOR_CHAR) begin
            k = KIND_MOTOR;
        end else if (sel == SERVO_CHAR) begin
            k = KIND_SERVO;
        end
        return k;
    endfunction

    // (units-48) + (tens-48)*10, modulo 256; tens*10 as two shifts
    function automatic logic [BYTE_W-1:0] value_of(input logic [BYTE_W-1:0] tens,
                                                   input logic [BYTE_W-1:0] units);
        logic [BYTE_W-1:0] t;
        logic [BYTE_W-1:0] u;
        t = tens - ASCII_ZERO;
        u = units - ASCII_ZERO;
        return u + (t << 3) + (t << 1);
    endfunction

    logic [FRAME_LEN-1:0] hit;
    t_idx                 pos;
    t_result              n_res;
    t_result              r_res;
    logic                 r_vld;

    always_comb begin
        for (int i = 0; i < FRAME_LEN; i++) begin
            hit[i] = (i_frm.bytes[i] == HDR_CHAR);
        end
        // lowest matching position wins
        pos = '0;
        for (int i = FRAME_LEN - 1; i >= 0; i--) begin
            if (hit[i]) begin
                pos = t_idx'(i);
            end
        end
    end

    always_comb begin
        n_res = '0;
        if (|hit) begin
            n_res.found        = 1'b1;
            n_res.first_kind   = kind_of(i_frm.bytes[pos + t_idx'(1)]);
            n_res.first_value  = value_of(i_frm.bytes[pos + t_idx'(2)],
                                          i_frm.bytes[pos + t_idx'(3)]);
            n_res.second_kind  = kind_of(i_frm.bytes[pos + t_idx'(4)]);
            n_res.second_value = value_of(i_frm.bytes[pos + t_idx'(5)],
                                          i_frm.bytes[pos + t_idx'(6)]);
        end
    end

    assign o_take = i_frm.vld && (!r_vld || i_m_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_take) begin
            r_vld <= 1'b1;
        end else if (i_m_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res <= n_res;
        end
    end

    assign o_m_valid = r_vld;
    assign o_res     = r_res;

endmodule

`default_nettype wire

// ===== rtl/actuator_frame_decoder_unit.sv =====
// Top level of the actuator frame decoder: byte collector plus decoder.
// Depends on afd_pkg, afd_collect and afd_decode.
//
//   channel | dir | payload                                      | handshake
//   s_      | in  | tdata[7:0] rx_byte                           | s_tvalid/s_tready
//   m_      | out | tdata: first_value, second_value            | m_tvalid/m_tready
//           |     | tuser: header_found, first_kind, second_kind |
//
// One byte per cycle sustained. After its eighth byte is accepted, a frame's result
// is held first in the frame snapshot register, then in the result register. Bytes
// are taken while a result waits; s_tready falls only when both the snapshot and
// the result register are full and m_tready is low.
// Synchronous active-low reset clears the byte count and both valid flags.
`default_nettype none

module actuator_frame_decoder_unit import afd_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // [7:0] rx_byte
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // [7:0] first_value, [15:8] second_value
    output logic [M_USER_W-1:0]      m_tuser    // [0] header_found, [2:1] first_kind,
                                                // [4:3] second_kind
);

    t_frm_xfer frm;
    logic      take;
    t_result   res;

    afd_collect u_collect (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .i_s_data  (s_tdata),
        .o_s_ready (s_tready),
        .i_take    (take),
        .o_frm     (frm)
    );

    afd_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_frm     (frm),
        .o_take    (take),
        .o_m_valid (m_tvalid),
        .i_m_ready (m_tready),
        .o_res     (res)
    );

    assign m_tdata = {res.second_value, res.first_value};
    assign m_tuser = {res.second_kind, res.first_kind, res.found};

endmodule

`default_nettype wire

// ===== rtl/afd_checker.sv =====
// Port-level checks for actuator_frame_decoder_unit, bound to the top level.
// Depends on afd_pkg.
`default_nettype none

module afd_checker import afd_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic [S_DATA_W-1:0] s_tdata,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic [M_USER_W-1:0] m_tuser
);

    logic s_xfer;
    assign s_xfer = s_tvalid && s_tready && (s_tdata == s_tdata);

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result transaction changed");

    a_no_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[0] |-> m_tuser[4:1] == 4'd0 && m_tdata == '0)
        else $error("frame without header carries a command");

    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tuser[2:1] != 2'd3 && m_tuser[4:3] != 2'd3)
        else $error("command kind out of range");

    // a frame snapshot can still sit in the snapshot register after its last byte, so
    // idle with no result pending on successive samples means nothing can come out
    a_needs_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_xfer && !m_tvalid ##1 !s_xfer && !m_tvalid |=> !m_tvalid)
        else $error("result with no input transaction");

endmodule

bind actuator_frame_decoder_unit afd_checker u_afd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
